>>> rtl/assert_macros.svh
// Assertion macros used by the top-level RTL module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on the same clock edge, off during reset.
`define SACL_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent on one edge, consequent on the next.
`define SACL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/sacl_pkg.sv
// Shared types and constants of the set-associative cache lookup.
package sacl_pkg;

  localparam int ADDR_W    = 32;
  localparam int STAMP_W   = 32;
  localparam int CFG_SETS_W = 7;
  localparam int CFG_WAYS_W = 3;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_SETS_W-1:0] SETS_RESET = 7'd64;
  localparam logic [CFG_WAYS_W-1:0] WAYS_RESET = 3'd4;

  localparam logic CFG_IDX_SETS = 1'b0;
  localparam logic CFG_IDX_WAYS = 1'b1;

  localparam logic [1:0] OUTCOME_HIT  = 2'd0;
  localparam logic [1:0] OUTCOME_CMP  = 2'd1;
  localparam logic [1:0] OUTCOME_REPL = 2'd2;

  localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

  // Remainder unit: one dividend bit per cycle.
  localparam int DIV_CNT_W = 5;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = 5'd31;

  typedef struct packed {
    logic busy;
    logic done;
  } rem_status_t;

  typedef struct packed {
    logic rd_row;
    logic rd_line;
    logic fill;
  } store_cmd_t;

endpackage

>>> rtl/sacl_rem.sv
// Bit-serial restoring remainder unit: address modulo the sets in use.
module sacl_rem
  import sacl_pkg::*;
#(
  parameter int SET_W  = 7,
  parameter int SET_IW = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [ADDR_W-1:0] dividend,
  input  logic [SET_W-1:0]  divisor,
  output rem_status_t       status,
  output logic [SET_IW-1:0] rem
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [ADDR_W-1:0]    dv;
  logic [SET_W-1:0]     rem_r;
  logic [SET_W:0]       trial;
  logic [SET_W:0]       diff;

  assign trial = {rem_r, dv[ADDR_W-1]};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      cnt   <= '0;
      dv    <= dividend;
      rem_r <= '0;
    end else if (busy) begin
      // partial remainder stays below the divisor, so it fits in SET_W bits
      if (trial >= {1'b0, divisor}) begin
        rem_r <= diff[SET_W-1:0];
      end else begin
        rem_r <= trial[SET_W-1:0];
      end
      dv  <= dv << 1;
      cnt <= cnt + 1'b1;
      if (cnt == DIV_LAST) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign rem         = rem_r[SET_IW-1:0];

endmodule

>>> rtl/sacl_store.sv
// Line storage: valid rows, line addresses and fill stamps, with a clearing pass.
module sacl_store
  import sacl_pkg::*;
#(
  parameter int SETS   = 64,
  parameter int WAYS   = 4,
  parameter int SET_IW = 6,
  parameter int WAY_IW = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  store_cmd_t         cmd,
  input  logic [SET_IW-1:0]  set_idx,
  input  logic [WAY_IW-1:0]  way_idx,
  input  logic [ADDR_W-1:0]  fill_addr,
  input  logic [STAMP_W-1:0] fill_stamp,
  input  logic [WAYS-1:0]    fill_row,
  output logic [WAYS-1:0]    row_q,
  output logic [ADDR_W-1:0]  addr_q,
  output logic [STAMP_W-1:0] stamp_q,
  output logic               clr_busy
);

  localparam int ENTRIES = SETS * WAYS;
  localparam int ENT_IW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [WAYS-1:0]    valid_mem [SETS];
  logic [ADDR_W-1:0]  addr_mem  [ENTRIES];
  logic [STAMP_W-1:0] stamp_mem [ENTRIES];

  logic [SET_IW-1:0]  clr_row;
  logic [31:0]        ent_full;
  logic [ENT_IW-1:0]  ent_idx;

  assign ent_full = 32'(set_idx) * 32'(WAYS) + 32'(way_idx);
  assign ent_idx  = ent_full[ENT_IW-1:0];

  // clearing pass: one valid row per cycle after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_row  <= '0;
    end else if (clr_busy) begin
      if (clr_row == SET_IW'(SETS - 1)) begin
        clr_busy <= 1'b0;
      end else begin
        clr_row <= clr_row + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      valid_mem[clr_row] <= '0;
    end else if (cmd.fill) begin
      valid_mem[set_idx] <= fill_row;
    end
    if (cmd.rd_row) begin
      row_q <= valid_mem[set_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fill) begin
      addr_mem[ent_idx]  <= fill_addr;
      stamp_mem[ent_idx] <= fill_stamp;
    end
    if (cmd.rd_line) begin
      addr_q  <= addr_mem[ent_idx];
      stamp_q <= stamp_mem[ent_idx];
    end
  end

endmodule

>>> rtl/set_assoc_cache_lookup.sv
// Top level: sequencer of the set-associative cache lookup with oldest-fill replacement.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    addr
//  m_axis    out  m_axis_tvalid/m_axis_tready    outcome, way
//  cfg       in   cfg_we                         cfg_index, cfg_data
//
// A miss runs from one accept to the earliest next one through these steps: the accept,
// the bit-serial set remainder and its handoff, the row read, a scan of the ways in use
// (one line read each), the fill and the load of the output register. A hit ends the
// scan at the hitting way and skips the fill.
// After reset a clearing pass runs over all SETS rows, during which no item is taken.
// The output register lets the next item be taken while a result waits; the load into
// it stalls only while that register still holds an unaccepted item.
module set_assoc_cache_lookup
  import sacl_pkg::*;
#(
  parameter int SETS = 64,
  parameter int WAYS = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [ADDR_W-1:0]     s_axis_tdata,   // [31:0] addr
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [7:0]            m_axis_tdata,   // [1:0] outcome, [3:2] way, [7:4] zero
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "assert_macros.svh"

  localparam int SET_W  = $clog2(SETS + 1);
  localparam int SET_IW = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W  = $clog2(WAYS + 1);
  localparam int WAY_IW = (WAYS > 1) ? $clog2(WAYS) : 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MOD   = 3'd1;
  localparam logic [2:0] ST_ROW   = 3'd2;
  localparam logic [2:0] ST_CHECK = 3'd3;
  localparam logic [2:0] ST_FILL  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]            state;
  logic [CFG_SETS_W-1:0] sets_in_use;
  logic [CFG_WAYS_W-1:0] ways_in_use;
  logic [SET_W-1:0]      nsets;
  logic [WAY_W-1:0]      nways;

  logic [ADDR_W-1:0]     addr_r;
  logic [SET_IW-1:0]     set_r;
  logic [WAY_IW-1:0]     cur_w;
  logic                  empty_v;
  logic [WAY_IW-1:0]     empty_w;
  logic                  best_v;
  logic [STAMP_W-1:0]    best_stamp;
  logic [WAY_IW-1:0]     victim_w;
  logic [STAMP_W-1:0]    fill_counter;
  logic [STAMP_W-1:0]    fill_counter_next;
  logic [1:0]            res_outcome;
  logic [1:0]            res_way;
  logic [1:0]            out_outcome;
  logic [1:0]            out_way;

  logic                  in_acc;
  logic                  hit;
  logic                  last_way;
  logic [WAY_IW-1:0]     fill_w;
  logic [WAY_IW-1:0]     store_way;
  logic [WAYS-1:0]       fill_row;

  rem_status_t           rem_stat;
  logic [SET_IW-1:0]     rem_val;
  store_cmd_t            cmd;
  logic [WAYS-1:0]       row_q;
  logic [ADDR_W-1:0]     addr_q;
  logic [STAMP_W-1:0]    stamp_q;
  logic                  clr_busy;

  // clamp the configured counts to 1..SETS and 1..WAYS
  always_comb begin
    if (sets_in_use == '0) begin
      nsets = SET_W'(1);
    end else if (32'(sets_in_use) > 32'(SETS)) begin
      nsets = SET_W'(SETS);
    end else begin
      nsets = SET_W'(sets_in_use);
    end
    if (ways_in_use == '0) begin
      nways = WAY_W'(1);
    end else if (32'(ways_in_use) > 32'(WAYS)) begin
      nways = WAY_W'(WAYS);
    end else begin
      nways = WAY_W'(ways_in_use);
    end
  end

  assign s_axis_tready = (state == ST_IDLE) && !clr_busy;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign hit           = row_q[cur_w] && (addr_q == addr_r);
  assign last_way      = (WAY_W'(cur_w) + WAY_W'(1)) == nways;
  assign fill_w        = empty_v ? empty_w : victim_w;
  assign fill_row      = row_q | (WAYS'(1) << fill_w);
  assign fill_counter_next = (fill_counter == STAMP_MAX) ? fill_counter
                                                         : fill_counter + 1'b1;

  always_comb begin
    cmd.rd_row  = (state == ST_ROW);
    cmd.rd_line = (state == ST_ROW) || ((state == ST_CHECK) && !hit && !last_way);
    cmd.fill    = (state == ST_FILL);
    unique case (state)
      ST_FILL:  store_way = fill_w;
      ST_CHECK: store_way = cur_w + 1'b1;
      default:  store_way = '0;
    endcase
  end

  sacl_rem #(
    .SET_W  (SET_W),
    .SET_IW (SET_IW)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (in_acc),
    .dividend (s_axis_tdata),
    .divisor  (nsets),
    .status   (rem_stat),
    .rem      (rem_val)
  );

  sacl_store #(
    .SETS   (SETS),
    .WAYS   (WAYS),
    .SET_IW (SET_IW),
    .WAY_IW (WAY_IW)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .set_idx    (set_r),
    .way_idx    (store_way),
    .fill_addr  (addr_r),
    .fill_stamp (fill_counter_next),
    .fill_row   (fill_row),
    .row_q      (row_q),
    .addr_q     (addr_q),
    .stamp_q    (stamp_q),
    .clr_busy   (clr_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sets_in_use <= SETS_RESET;
      ways_in_use <= WAYS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_SETS: sets_in_use <= cfg_data[CFG_SETS_W-1:0];
        CFG_IDX_WAYS: ways_in_use <= cfg_data[CFG_WAYS_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      fill_counter  <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // in ST_DONE the load below decides tvalid on its own
      if (m_axis_tvalid && m_axis_tready && (state != ST_DONE)) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            addr_r <= s_axis_tdata;
            state  <= ST_MOD;
          end
        end
        ST_MOD: begin
          if (rem_stat.done) begin
            set_r <= rem_val;
            state <= ST_ROW;
          end
        end
        ST_ROW: begin
          cur_w   <= '0;
          empty_v <= 1'b0;
          best_v  <= 1'b0;
          state   <= ST_CHECK;
        end
        ST_CHECK: begin
          if (hit) begin
            res_outcome <= OUTCOME_HIT;
            res_way     <= 2'(cur_w);
            state       <= ST_DONE;
          end else begin
            if (!row_q[cur_w] && !empty_v) begin
              empty_v <= 1'b1;
              empty_w <= cur_w;
            end
            // strict compare keeps the lowest way on a tie
            if (row_q[cur_w] && (!best_v || stamp_q < best_stamp)) begin
              best_v     <= 1'b1;
              best_stamp <= stamp_q;
              victim_w   <= cur_w;
            end
            if (last_way) begin
              state <= ST_FILL;
            end else begin
              cur_w <= cur_w + 1'b1;
            end
          end
        end
        ST_FILL: begin
          fill_counter <= fill_counter_next;
          res_outcome  <= empty_v ? OUTCOME_CMP : OUTCOME_REPL;
          res_way      <= 2'(fill_w);
          state        <= ST_DONE;
        end
        ST_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            out_outcome   <= res_outcome;
            out_way       <= res_way;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tdata = {4'b0000, out_way, out_outcome};

  `SACL_ASSERT(a_fill_after_clear, clk, rst, (state == ST_FILL) |-> !clr_busy, "fill during clearing pass")
  `SACL_ASSERT_NEXT(a_accept_starts_rem, clk, rst, in_acc, (state == ST_MOD) && rem_stat.busy, "accepted item did not start the remainder unit")
  `SACL_ASSERT(a_counter_monotonic, clk, rst, !$past(rst) |-> (fill_counter >= $past(fill_counter)), "fill counter went backward")
  `SACL_ASSERT(a_replace_only_full, clk, rst, ((state == ST_FILL) && !empty_v) |-> best_v, "replacement without a valid victim")

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the set-associative cache lookup with oldest-fill replacement.
module tb;
  import sacl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETS = 64;
  localparam int WAYS = 4;
  localparam int DRAIN_CYCLES = 60;
  localparam int QUIET_LIMIT = 3000;
  localparam int POOL_SIZE = 12;

  typedef struct packed {
    logic [1:0] outcome;
    logic [1:0] way;
  } lookup_res_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [ADDR_W-1:0]     s_axis_tdata = '0;   // [31:0] addr
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b1;
  logic [7:0]            m_axis_tdata;        // [1:0] outcome, [3:2] way, [7:4] zero
  logic                  cfg_we = 1'b0;
  logic                  cfg_index = CFG_IDX_SETS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  set_assoc_cache_lookup #(.SETS(SETS), .WAYS(WAYS)) dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Mirror of the cache contents and settings
  bit                  line_ok    [SETS*WAYS];
  logic [ADDR_W-1:0]   line_tag   [SETS*WAYS];
  logic [STAMP_W-1:0]  line_stamp [SETS*WAYS];
  logic [STAMP_W-1:0]  fill_count = '0;
  logic [CFG_SETS_W-1:0] sets_cfg = SETS_RESET;
  logic [CFG_WAYS_W-1:0] ways_cfg = WAYS_RESET;

  lookup_res_t pending_lookups[$];
  bit          gaps_on = 1'b1;
  int          fail_count = 0;
  int          n_hit = 0, n_cmp = 0, n_repl = 0, n_settings = 1;
  int          quiet_cycles = 0;
  logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

  function automatic int unsigned clamp_count(input int unsigned v, input int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic void fill_slot(input int unsigned slot, input logic [ADDR_W-1:0] a);
    if (fill_count != STAMP_MAX) fill_count++;
    line_ok[slot] = 1'b1;
    line_tag[slot] = a;
    line_stamp[slot] = fill_count;
  endfunction

  // Look up one address in the mirror, update it, and return the expected result
  function automatic lookup_res_t cache_lookup(input logic [ADDR_W-1:0] a);
    int unsigned nsets, nways, base, victim;
    logic [STAMP_W-1:0] oldest;
    lookup_res_t r;
    nsets = clamp_count(sets_cfg, SETS);
    nways = clamp_count(ways_cfg, WAYS);
    base = (a % nsets) * WAYS;
    for (int unsigned w = 0; w < nways; w++) begin
      if (line_ok[base+w] && line_tag[base+w] == a) begin
        r.outcome = OUTCOME_HIT;
        r.way = w[1:0];
        return r;
      end
    end
    for (int unsigned w = 0; w < nways; w++) begin
      if (!line_ok[base+w]) begin
        fill_slot(base + w, a);
        r.outcome = OUTCOME_CMP;
        r.way = w[1:0];
        return r;
      end
    end
    victim = 0;
    oldest = line_stamp[base];
    for (int unsigned w = 1; w < nways; w++) begin
      if (line_stamp[base+w] < oldest) begin
        oldest = line_stamp[base+w];
        victim = w;
      end
    end
    fill_slot(base + victim, a);
    r.outcome = OUTCOME_REPL;
    r.way = victim[1:0];
    return r;
  endfunction

  // tvalid is left high after acceptance so back-to-back items need one assignment per step
  task automatic send_addr(input logic [ADDR_W-1:0] a);
    while (gaps_on && $urandom_range(0, 99) < 8) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= a;
    do @(posedge clk); while (!s_axis_tready);
    pending_lookups.push_back(cache_lookup(a));
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == CFG_IDX_SETS) sets_cfg = val[CFG_SETS_W-1:0];
    else ways_cfg = val[CFG_WAYS_W-1:0];
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_geometry(input logic [CFG_DATA_W-1:0] sets, input logic [CFG_DATA_W-1:0] ways);
    wait_idle();
    write_reg(CFG_IDX_SETS, sets);
    write_reg(CFG_IDX_WAYS, ways);
    n_settings++;
  endtask

  // Reset geometry: fill a set, hit, then evict in fill order
  task automatic test_reset_lookups();
    send_addr(32'h0000_0000);
    send_addr(32'h0000_0000);
    send_addr(32'h0000_0040);
    send_addr(32'h0000_0080);
    send_addr(32'hFFFF_FFC0);
    send_addr(32'h0000_0040);
    send_addr(32'hDEAD_BEC0);
    send_addr(32'h0000_0000);
    send_addr(32'hFFFF_FFFF);
    send_addr(32'h7FFF_FFFF);
    send_addr(32'hFFFF_FFFF);
    send_addr(32'h8000_0000);
    send_addr(32'h5555_5555);
    send_addr(32'hAAAA_AAAA);
  endtask

  // Zero and oversize register values, plus lines left outside the ways in use
  task automatic test_config_limits();
    set_geometry(7'd0, 7'd0);
    send_addr(32'h1234_5678);
    send_addr(32'h1234_5678);
    send_addr(32'h0000_0040);
    set_geometry(7'd127, 7'd7);
    send_addr(32'hFFFF_FFFF);
    send_addr(32'h0000_0040);
    set_geometry(7'd65, 7'b1111_010);   // upper data bits are not part of the way count
    send_addr(32'hDEAD_BEC0);
    send_addr(32'h0000_0100);
    set_geometry(7'd1, 7'd4);
    send_addr(32'h0000_0003);
    send_addr(32'h1234_5678);
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] sets, input logic [CFG_DATA_W-1:0] ways,
                           input int n, input bit gaps);
    int unsigned ns;
    logic [ADDR_W-1:0] a;
    int pick;
    set_geometry(sets, ways);
    gaps_on = gaps;
    ns = clamp_count(sets_cfg, SETS);
    // a few hot sets so that hits and evictions are common
    foreach (addr_pool[i]) begin
      a = $urandom();
      addr_pool[i] = a - (a % ns) + ($urandom_range(0, 2) % ns);
    end
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) a = addr_pool[$urandom_range(0, POOL_SIZE-1)];
      else if (pick < 85) a = addr_pool[$urandom_range(0, POOL_SIZE-1)] ^ (32'h1 << $urandom_range(0, 31));
      else a = $urandom();
      send_addr(a);
    end
  endtask

  task automatic test_random_traffic();
    run_phase(7'd64, 7'd4, 66, 1'b1);
    run_phase(7'd1, 7'd4, 66, 1'b1);
    run_phase(7'd7, 7'd3, 66, 1'b1);
    run_phase(7'd0, 7'd0, 66, 1'b1);
    run_phase(7'd127, 7'd7, 66, 1'b1);
    run_phase(7'd33, 7'd2, 66, 1'b1);
    run_phase(7'd64, 7'd1, 66, 1'b1);
    run_phase(7'd5, 7'd4, 66, 1'b0);
    gaps_on = 1'b1;
  endtask

  // Result side: random stalls and the compare against the oldest expectation
  always @(posedge clk) begin
    lookup_res_t exp_res;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_lookups.size() == 0) begin
        $error("result with nothing expected: tdata %h", m_axis_tdata);
        fail_count++;
      end else begin
        exp_res = pending_lookups.pop_front();
        if (m_axis_tdata[1:0] !== exp_res.outcome) begin
          $error("outcome: expected %0d, got %0d", exp_res.outcome, m_axis_tdata[1:0]);
          fail_count++;
        end
        if (m_axis_tdata[3:2] !== exp_res.way) begin
          $error("way: expected %0d, got %0d", exp_res.way, m_axis_tdata[3:2]);
          fail_count++;
        end
        case (exp_res.outcome)
          OUTCOME_HIT: n_hit++;
          OUTCOME_CMP: n_cmp++;
          default: n_repl++;
        endcase
      end
    end
    m_axis_tready <= !(gaps_on && $urandom_range(0, 99) < 8);
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: %0d lookups still outstanding", pending_lookups.size());
        $display("tb failed");
        $finish;
      end
    end
  end

  initial begin
    foreach (line_ok[i]) line_ok[i] = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_reset_lookups();
    test_config_limits();
    test_random_traffic();
    wait_idle();
    $display("checked %0d lookups: %0d hits, %0d compulsory misses, %0d replacements",
             n_hit + n_cmp + n_repl, n_hit, n_cmp, n_repl);
    $display("across %0d set/way settings, including zero and oversize register values",
             n_settings);
    if (fail_count == 0 && pending_lookups.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

>>> set_assoc_cache_lookup.f
+incdir+rtl
rtl/sacl_pkg.sv
rtl/sacl_rem.sv
rtl/sacl_store.sv
rtl/set_assoc_cache_lookup.sv
tb/sv/tb.sv
